@@ design/tqh_pkg.sv @@
package tqh_pkg;

    // DEPTH must be a power of two: queue slots wrap by truncation.
    localparam int DEPTH = 64;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int TW    = 32;

    typedef enum logic [3:0] {
        OP_ADD_BACK   = 4'd0,
        OP_ADD_FRONT  = 4'd1,
        OP_SERVE      = 4'd2,
        OP_UNDO       = 4'd3,
        OP_REDO       = 4'd4,
        OP_PEEK_QUEUE = 4'd5,
        OP_PEEK_HIST  = 4'd6,
        OP_LIST_QUEUE = 4'd7,
        OP_LIST_HIST  = 4'd8
    } op_t;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_QUEUE_FULL   = 3'd1,
        ST_QUEUE_EMPTY  = 3'd2,
        ST_HIST_FULL    = 3'd3,
        ST_NO_UNDO      = 3'd4,
        ST_NO_REDO      = 3'd5,
        ST_HIST_EMPTY   = 3'd6
    } status_t;

    typedef struct packed {
        logic accept;     // latch the input word
        logic load_check; // emit add result or error result, apply add
        logic load_data;  // emit result from read data, apply stack moves
        logic step;       // advance list index
    } cmd_t;

    typedef struct packed {
        logic unknown;
        logic fail;
        logic is_add;
        logic is_list;
        logic list_last;
        logic out_free;
    } stat_t;

endpackage

@@ design/tqh_ctrl.sv @@
module tqh_ctrl
    import tqh_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_tvalid,
    output logic  s_tready,
    input  stat_t stat,
    output cmd_t  cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_DATA
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                priority if (stat.unknown) begin
                    state_next = S_IDLE;
                end else if (stat.fail || stat.is_add) begin
                    if (stat.out_free) begin
                        cmd.load_check = 1'b1;
                        state_next     = S_IDLE;
                    end
                end else begin
                    state_next = S_DATA;
                end
            end
            S_DATA: begin
                if (stat.out_free) begin
                    cmd.load_data = 1'b1;
                    if (stat.is_list && !stat.list_last) begin
                        cmd.step   = 1'b1;
                        state_next = S_CHECK;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

@@ design/tqh_dp.sv @@
module tqh_dp
    import tqh_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  cmd_t          cmd,
    output stat_t         stat,
    input  logic [3:0]    in_op,
    input  logic [TW-1:0] in_ticket,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [TW-1:0] out_ticket,
    output status_t       out_status,
    output logic          out_tkv,
    output logic          out_last
);

    logic [TW-1:0] queue_mem [DEPTH];
    logic [TW-1:0] hist_mem  [DEPTH];
    logic [TW-1:0] redo_mem  [DEPTH];

    op_t           op_reg;
    logic [TW-1:0] tk_reg;
    logic [AW-1:0] idx_reg;
    logic [AW-1:0] head_reg;
    logic [CW-1:0] qc_reg, hc_reg, rc_reg;
    logic [TW-1:0] q_rd_reg, h_rd_reg, r_rd_reg;

    logic          out_valid_reg;
    logic [TW-1:0] out_ticket_reg;
    status_t       out_status_reg;
    logic          out_tkv_reg, out_last_reg;

    logic          q_full, q_empty, h_full, h_empty, r_full, r_empty;
    status_t       err_code;
    logic [AW-1:0] q_raddr, h_raddr, r_raddr, q_waddr;
    logic          q_we, h_we, r_we;
    logic [TW-1:0] h_wdata, data_tk;
    logic [CW-1:0] list_cnt;

    assign q_full  = (qc_reg == CW'(DEPTH));
    assign q_empty = (qc_reg == '0);
    assign h_full  = (hc_reg == CW'(DEPTH));
    assign h_empty = (hc_reg == '0);
    assign r_full  = (rc_reg == CW'(DEPTH));
    assign r_empty = (rc_reg == '0);

    always_comb begin
        stat.unknown = 1'b0;
        stat.fail    = 1'b0;
        stat.is_add  = 1'b0;
        stat.is_list = 1'b0;
        err_code     = ST_OK;
        list_cnt     = qc_reg;
        data_tk      = q_rd_reg;
        unique case (op_reg)
            OP_ADD_BACK, OP_ADD_FRONT: begin
                stat.is_add = 1'b1;
                stat.fail   = q_full;
                err_code    = ST_QUEUE_FULL;
            end
            OP_SERVE, OP_PEEK_QUEUE: begin
                stat.fail = q_empty;
                err_code  = ST_QUEUE_EMPTY;
            end
            OP_LIST_QUEUE: begin
                stat.is_list = 1'b1;
                stat.fail    = q_empty;
                err_code     = ST_QUEUE_EMPTY;
            end
            OP_UNDO: begin
                stat.fail = h_empty || r_full;
                err_code  = ST_NO_UNDO;
                data_tk   = h_rd_reg;
            end
            OP_REDO: begin
                stat.fail = r_empty || h_full;
                err_code  = ST_NO_REDO;
                data_tk   = r_rd_reg;
            end
            OP_PEEK_HIST: begin
                stat.fail = h_empty;
                err_code  = ST_HIST_EMPTY;
                data_tk   = h_rd_reg;
            end
            OP_LIST_HIST: begin
                stat.is_list = 1'b1;
                stat.fail    = h_empty;
                err_code     = ST_HIST_EMPTY;
                list_cnt     = hc_reg;
                data_tk      = h_rd_reg;
            end
            default: stat.unknown = 1'b1;
        endcase
        stat.list_last = ({1'b0, idx_reg} + CW'(1)) == list_cnt;
        stat.out_free  = !out_valid_reg || out_ready;
    end

    // Read addresses; history lists from the top down.
    assign q_raddr = head_reg + idx_reg;
    assign h_raddr = hc_reg[AW-1:0] - AW'(1) - idx_reg;
    assign r_raddr = rc_reg[AW-1:0] - AW'(1);

    assign q_waddr = (op_reg == OP_ADD_FRONT) ? head_reg - AW'(1)
                                              : head_reg + qc_reg[AW-1:0];
    assign q_we    = cmd.load_check && stat.is_add && !stat.fail;
    assign h_we    = cmd.load_data && ((op_reg == OP_SERVE && !h_full) || op_reg == OP_REDO);
    assign r_we    = cmd.load_data && (op_reg == OP_UNDO);
    assign h_wdata = (op_reg == OP_REDO) ? r_rd_reg : q_rd_reg;

    always_ff @(posedge aclk) begin
        if (q_we) begin
            queue_mem[q_waddr] <= tk_reg;
        end
        if (h_we) begin
            hist_mem[hc_reg[AW-1:0]] <= h_wdata;
        end
        if (r_we) begin
            redo_mem[rc_reg[AW-1:0]] <= h_rd_reg;
        end
        q_rd_reg <= queue_mem[q_raddr];
        h_rd_reg <= hist_mem[h_raddr];
        r_rd_reg <= redo_mem[r_raddr];
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            op_reg  <= op_t'(in_op);
            tk_reg  <= in_ticket;
            idx_reg <= '0;
        end else if (cmd.step) begin
            idx_reg <= idx_reg + AW'(1);
        end
        if (cmd.load_check) begin
            out_status_reg <= stat.fail ? err_code : ST_OK;
            out_tkv_reg    <= !stat.fail;
            out_ticket_reg <= stat.fail ? '0 : tk_reg;
            out_last_reg   <= 1'b1;
        end else if (cmd.load_data) begin
            out_status_reg <= (op_reg == OP_SERVE && h_full) ? ST_HIST_FULL : ST_OK;
            out_tkv_reg    <= 1'b1;
            out_ticket_reg <= data_tk;
            out_last_reg   <= stat.is_list ? stat.list_last : 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            head_reg      <= '0;
            qc_reg        <= '0;
            hc_reg        <= '0;
            rc_reg        <= '0;
        end else begin
            if (cmd.load_check || cmd.load_data) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (q_we) begin
                qc_reg <= qc_reg + CW'(1);
                if (op_reg == OP_ADD_FRONT) begin
                    head_reg <= head_reg - AW'(1);
                end
            end
            if (cmd.load_data) begin
                unique case (op_reg)
                    OP_SERVE: begin
                        head_reg <= head_reg + AW'(1);
                        qc_reg   <= qc_reg - CW'(1);
                        if (!h_full) begin
                            hc_reg <= hc_reg + CW'(1);
                            rc_reg <= '0;
                        end
                    end
                    OP_UNDO: begin
                        hc_reg <= hc_reg - CW'(1);
                        rc_reg <= rc_reg + CW'(1);
                    end
                    OP_REDO: begin
                        rc_reg <= rc_reg - CW'(1);
                        hc_reg <= hc_reg + CW'(1);
                    end
                    default: ;
                endcase
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_ticket = out_ticket_reg;
    assign out_status = out_status_reg;
    assign out_tkv    = out_tkv_reg;
    assign out_last   = out_last_reg;

endmodule

@@ design/ticket_queue_with_undo_history_top.sv @@
// Ticket queue with served-ticket history and undo/redo. Each input word asks for one
// operation; each word gives one result word, except queue and history listings, which
// give one result per stored ticket, the final one marked by m_tlast, and unknown
// operation codes, which give none. One word is in work at a time. Adds, refused
// operations and unknown codes are handled without a memory read; every other operation
// does a registered read of one of the three 64-entry memories, then the update, and a
// listing does one such read per listed ticket. The result register holds while
// m_tready is low. A waiting result does not block the next input.
module ticket_queue_with_undo_history_top
    import tqh_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,  // passenger_id, origin_station, destination_station
    input  logic [3:0]  s_tuser,  // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,  // out_passenger_id, out_origin_station,
                                  // out_destination_station
    output logic [3:0]  m_tuser,  // ticket_valid (bit 3), status (bits 2:0)
    output logic        m_tlast
);

    cmd_t    cmd;
    stat_t   stat;
    status_t out_status;
    logic    out_tkv;

    tqh_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    tqh_dp u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .in_op      (s_tuser),
        .in_ticket  (s_tdata),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_ticket (m_tdata),
        .out_status (out_status),
        .out_tkv    (out_tkv),
        .out_last   (m_tlast)
    );

    assign m_tuser = {out_tkv, out_status};

    a_no_ticket_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[3] |-> m_tdata == '0)
        else $error("result without ticket carries nonzero ticket fields");

    a_ok_has_ticket: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[2:0] == ST_OK |-> m_tuser[3])
        else $error("ok status without ticket");

    a_mid_list_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tuser[2:0] == ST_OK && m_tuser[3])
        else $error("non-final result is not a listed ticket");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while previous word still in work");

endmodule
